>>> rtl/core/ptts_pkg.sv
// Shared types and codes for the periodic task timer slots block.
package ptts_pkg;

   localparam int OP_W        = 3;
   localparam int SLOT_W      = 4;
   localparam int DELAY_W     = 16;
   localparam int TIME_W      = 32;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_TICK      = 3'd0;
   localparam op_type OP_ADD       = 3'd1;
   localparam op_type OP_REMOVE    = 3'd2;
   localparam op_type OP_TAKE_DUE  = 3'd3;
   localparam op_type OP_SET_TIME  = 3'd4;
   localparam op_type OP_READ_TIME = 3'd5;

   typedef struct packed {
      op_type               operation;
      logic [SLOT_W-1:0]    slot;
      logic [DELAY_W-1:0]   initial_delay;
      logic [DELAY_W-1:0]   reload_period;
      logic [TIME_W-1:0]    time_value;
   } req_type;

   typedef struct packed {
      logic                 accepted;
      logic [SLOT_W-1:0]    due_slot;
      logic [TIME_W-1:0]    time_now;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_SCAN,
      ST_ADD_WR,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_TICK,
      MODE_ADD,
      MODE_UNLINK,
      MODE_SEARCH
   } mode_type;

endpackage

>>> rtl/core/periodic_task_timer_slots.sv
// Top level of the periodic task timer slots block.
// Set time, read time, refused add or remove and unknown codes go straight to the result;
// tick and take due walk the slots, add and remove too, a one-shot take due walks them twice.
// One item at a time: the next request is taken only after the result is loaded, and one
// shared decrementer with one read and one write port per slot memory walks all slots.
// Reset clears the state machine, the active and due marks, the time counter and the result valid flag.
module periodic_task_timer_slots #(
   parameter int SLOTS       = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ptts_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ptts_pkg::rsp_type    rsp_payload
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = COUNT_WIDTH;

   ptts_pkg::state_type state_ff, state_in;
   ptts_pkg::mode_type  mode_ff, mode_in;
   logic [SW:0]         cnt_ff, cnt_in;
   ptts_pkg::op_type    op_ff, op_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [CW-1:0]       delay_ff, delay_in;
   logic [CW-1:0]       per_ff, per_in;
   logic                found_ff, found_in;
   logic                acc_ff, acc_in;
   logic [SW-1:0]       best_ff, best_in;
   logic [SW-1:0]       best_rank_ff, best_rank_in;
   logic                best_pz_ff, best_pz_in;
   logic [SW-1:0]       tgt_ff, tgt_in;
   logic [SW-1:0]       tgt_rank_ff, tgt_rank_in;
   logic [SLOTS-1:0]    active_ff, active_in;
   logic [SLOTS-1:0]    due_ff, due_in;
   logic [31:0]         tick_ff, tick_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ptts_pkg::rsp_type   rsp_ff, rsp_in;

   logic [CW-1:0]       cd_mem [SLOTS];
   logic [CW-1:0]       per_mem [SLOTS];
   logic [SW-1:0]       rank_mem [SLOTS];
   logic [CW-1:0]       cd_rd_ff;
   logic [CW-1:0]       per_rd_ff;
   logic [SW-1:0]       rank_rd_ff;

   logic [SW-1:0]       rd_addr;
   logic [SW-1:0]       wr_addr;
   logic                cd_we, per_we, rank_we;
   logic [CW-1:0]       cd_wd;
   logic [SW-1:0]       rank_wd;

   logic [SW-1:0]       req_idx;
   logic                req_in_range;
   logic                add_ok, rem_ok;
   logic [SW:0]         cnt_dec;
   logic [SW-1:0]       pidx;
   logic                proc, last, rsp_free;

   assign req_idx      = SW'(req_payload.slot);
   assign req_in_range = int'(req_payload.slot) < SLOTS;
   assign add_ok       = req_in_range && !active_ff[req_idx];
   assign rem_ok       = req_in_range && active_ff[req_idx];
   assign cnt_dec      = cnt_ff - 1'b1;
   assign pidx         = cnt_dec[SW-1:0];
   assign proc         = (state_ff == ptts_pkg::ST_SCAN) && (cnt_ff != '0);
   assign last         = (state_ff == ptts_pkg::ST_SCAN) && (int'(cnt_ff) == SLOTS);
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   assign req_ready    = (state_ff == ptts_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptts_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.operation)
                  ptts_pkg::OP_TICK:     state_in = ptts_pkg::ST_SCAN;
                  ptts_pkg::OP_ADD:      state_in = add_ok ? ptts_pkg::ST_SCAN
                                                           : ptts_pkg::ST_DONE;
                  ptts_pkg::OP_REMOVE:   state_in = rem_ok ? ptts_pkg::ST_RANK
                                                           : ptts_pkg::ST_DONE;
                  ptts_pkg::OP_TAKE_DUE: state_in = ptts_pkg::ST_SCAN;
                  default:               state_in = ptts_pkg::ST_DONE;
               endcase
            end
         end
         ptts_pkg::ST_RANK:   state_in = ptts_pkg::ST_SCAN;
         ptts_pkg::ST_SCAN: begin
            if (last) begin
               if (mode_ff == ptts_pkg::MODE_ADD) begin
                  state_in = ptts_pkg::ST_ADD_WR;
               end else if (mode_ff == ptts_pkg::MODE_SEARCH && found_in && best_pz_in) begin
                  state_in = ptts_pkg::ST_SCAN;
               end else begin
                  state_in = ptts_pkg::ST_DONE;
               end
            end
         end
         ptts_pkg::ST_ADD_WR: state_in = ptts_pkg::ST_DONE;
         ptts_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = ptts_pkg::ST_IDLE;
            end
         end
         default:             state_in = ptts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      delay_in     = delay_ff;
      per_in       = per_ff;
      found_in     = found_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      best_rank_in = best_rank_ff;
      best_pz_in   = best_pz_ff;
      tgt_in       = tgt_ff;
      tgt_rank_in  = tgt_rank_ff;
      active_in    = active_ff;
      due_in       = due_ff;
      tick_in      = tick_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = '0;
      wr_addr      = pidx;
      cd_we        = 1'b0;
      per_we       = 1'b0;
      rank_we      = 1'b0;
      cd_wd        = '0;
      rank_wd      = '0;
      case (state_ff)
         ptts_pkg::ST_IDLE: begin
            rd_addr = req_idx;
            if (req_valid) begin
               op_in    = req_payload.operation;
               slot_in  = req_idx;
               delay_in = CW'(req_payload.initial_delay);
               per_in   = CW'(req_payload.reload_period);
               found_in = 1'b0;
               acc_in   = 1'b0;
               best_in  = '0;
               cnt_in   = '0;
               tgt_in   = req_idx;
               case (req_payload.operation)
                  ptts_pkg::OP_TICK: begin
                     tick_in = tick_ff + 32'd1;
                     mode_in = ptts_pkg::MODE_TICK;
                  end
                  ptts_pkg::OP_ADD: begin
                     mode_in = ptts_pkg::MODE_ADD;
                     acc_in  = add_ok;
                  end
                  ptts_pkg::OP_REMOVE:   mode_in = ptts_pkg::MODE_UNLINK;
                  ptts_pkg::OP_TAKE_DUE: mode_in = ptts_pkg::MODE_SEARCH;
                  ptts_pkg::OP_SET_TIME: tick_in = req_payload.time_value;
                  default:               mode_in = mode_ff;
               endcase
            end
         end
         ptts_pkg::ST_RANK: begin
            tgt_rank_in = rank_rd_ff;
            cnt_in      = '0;
         end
         ptts_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (int'(cnt_ff) < SLOTS) begin
               rd_addr = cnt_ff[SW-1:0];
            end
            if (proc && active_ff[pidx]) begin
               case (mode_ff)
                  ptts_pkg::MODE_TICK: begin
                     cd_we = 1'b1;
                     if (cd_rd_ff != '0) begin
                        cd_wd = cd_rd_ff - 1'b1;
                     end else begin
                        cd_wd        = per_rd_ff;
                        due_in[pidx] = 1'b1;
                     end
                  end
                  ptts_pkg::MODE_ADD: begin
                     rank_we = 1'b1;
                     rank_wd = rank_rd_ff + 1'b1;
                  end
                  ptts_pkg::MODE_UNLINK: begin
                     if (pidx != tgt_ff && rank_rd_ff > tgt_rank_ff) begin
                        rank_we = 1'b1;
                        rank_wd = rank_rd_ff - 1'b1;
                     end
                  end
                  ptts_pkg::MODE_SEARCH: begin
                     if (due_ff[pidx] && (!found_ff || rank_rd_ff < best_rank_ff)) begin
                        found_in     = 1'b1;
                        best_in      = pidx;
                        best_rank_in = rank_rd_ff;
                        best_pz_in   = (per_rd_ff == '0);
                     end
                  end
                  default: cd_we = 1'b0;
               endcase
            end
            if (last) begin
               cnt_in = '0;
               case (mode_ff)
                  ptts_pkg::MODE_UNLINK: begin
                     active_in[tgt_ff] = 1'b0;
                     due_in[tgt_ff]    = 1'b0;
                  end
                  ptts_pkg::MODE_SEARCH: begin
                     acc_in = found_in;
                     if (found_in) begin
                        due_in[best_in] = 1'b0;
                        if (best_pz_in) begin
                           tgt_in      = best_in;
                           tgt_rank_in = best_rank_in;
                           mode_in     = ptts_pkg::MODE_UNLINK;
                        end
                     end
                  end
                  default: cnt_in = '0;
               endcase
            end
         end
         ptts_pkg::ST_ADD_WR: begin
            wr_addr            = slot_ff;
            cd_we              = 1'b1;
            cd_wd              = delay_ff;
            per_we             = 1'b1;
            rank_we            = 1'b1;
            rank_wd            = '0;
            active_in[slot_ff] = 1'b1;
            due_in[slot_ff]    = 1'b0;
         end
         ptts_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.accepted      = acc_ff;
               rsp_in.due_slot      = (op_ff == ptts_pkg::OP_TAKE_DUE && acc_ff)
                                      ? ptts_pkg::SLOT_W'(best_ff) : '0;
               rsp_in.time_now      = tick_ff;
            end
         end
         default: cnt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cd_we) begin
         cd_mem[wr_addr] <= cd_wd;
      end
      cd_rd_ff <= cd_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (per_we) begin
         per_mem[wr_addr] <= per_ff;
      end
      per_rd_ff <= per_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[wr_addr] <= rank_wd;
      end
      rank_rd_ff <= rank_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptts_pkg::ST_IDLE;
         active_ff    <= '0;
         due_ff       <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         due_ff       <= due_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      cnt_ff       <= cnt_in;
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      delay_ff     <= delay_in;
      per_ff       <= per_in;
      found_ff     <= found_in;
      acc_ff       <= acc_in;
      best_ff      <= best_in;
      best_rank_ff <= best_rank_in;
      best_pz_ff   <= best_pz_in;
      tgt_ff       <= tgt_in;
      tgt_rank_ff  <= tgt_rank_in;
      rsp_ff       <= rsp_in;
   end

   // A slot can only be due while it is active.
   assert property (@(posedge clock) disable iff (reset)
      (due_ff & ~active_ff) == '0)
      else $error("due mark set on an inactive slot");

   // The slot walk never runs past the last slot.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ptts_pkg::ST_SCAN |-> int'(cnt_ff) <= SLOTS)
      else $error("slot walk counter out of range");

   // Writing an added slot makes it active on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ptts_pkg::ST_ADD_WR |=> active_ff[$past(slot_ff)])
      else $error("added slot not active");

   // A finished item whose result register is free always produces a beat.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptts_pkg::ST_DONE && rsp_free) |=> rsp_valid_ff)
      else $error("result beat lost");

endmodule
